// File: sv/ialu_pkg.sv
// Shared operation codes, item classes and queue status for the integer ALU.
package ialu_pkg;

  // Operation codes as carried on the operation port
  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_AND = 5'd4,
    OP_OR  = 5'd5,
    OP_XOR = 5'd6,
    OP_NOT = 5'd7,
    OP_SHL = 5'd8,
    OP_SAR = 5'd9,
    OP_ROL = 5'd10,
    OP_ROR = 5'd11,
    OP_EQ  = 5'd12,
    OP_GT  = 5'd13,
    OP_LT  = 5'd14,
    OP_GE  = 5'd15,
    OP_LE  = 5'd16
  } op_t;

  // Execution class chosen by the front end
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Queue occupancy seen by both ends
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// File: sv/ialu_front.sv
// Front end: takes input words, trims operands, reduces the shift and classifies.
module ialu_front #(
  parameter int WORD_BITS = 128,
  parameter int ENTRY_W   = 2 + 5 + 7 + 2 * WORD_BITS
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           operation,
  input  logic [63:0]          a_high,
  input  logic [63:0]          a_low,
  input  logic [63:0]          b_high,
  input  logic [63:0]          b_low,
  input  logic [6:0]           shift_amount,
  input  ialu_pkg::q_status_t  q_status,
  output logic                 push,
  output logic [ENTRY_W-1:0]   entry
);
  import ialu_pkg::*;

  localparam logic [7:0] W8 = 8'(WORD_BITS);

  logic [127:0]         a_full;
  logic [127:0]         b_full;
  logic [WORD_BITS-1:0] a_w;
  logic [WORD_BITS-1:0] b_w;
  logic [7:0]           s_ext;
  logic [6:0]           s_mod;
  logic                 b_zero;
  cls_t                 cls;

  // Accept whenever the queue has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Keep the low word of each operand
  assign a_full = {a_high, a_low};
  assign b_full = {b_high, b_low};
  assign a_w    = a_full[WORD_BITS-1:0];
  assign b_w    = b_full[WORD_BITS-1:0];

  // Reduce the shift count into the word; one subtract suffices
  assign s_ext = {1'b0, shift_amount};
  assign s_mod = 7'((s_ext >= W8) ? (s_ext - W8) : s_ext);

  // Route long operations to their units; a zero divisor finishes at once
  assign b_zero = (b_w == '0);
  always_comb begin
    if (operation == OP_MUL) begin
      cls = CLS_MUL;
    end else if (operation == OP_DIV && !b_zero) begin
      cls = CLS_DIV;
    end else begin
      cls = CLS_SIMPLE;
    end
  end

  assign entry = {cls, operation, s_mod, a_w, b_w};

endmodule

// File: sv/ialu_queue.sv
// Short queue between the front and back ends.
module ialu_queue #(
  parameter int DATA_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  logic                pop,
  output logic [DATA_W-1:0]   head,
  output ialu_pkg::q_status_t status
);
  import ialu_pkg::*;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

// File: sv/ialu_back.sv
// Back end: simple operations, shared 32x32 multiplier, bit-serial divider, output register.
module ialu_back #(
  parameter int WORD_BITS = 128,
  parameter int ENTRY_W   = 2 + 5 + 7 + 2 * WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ialu_pkg::q_status_t  q_status,
  input  logic [ENTRY_W-1:0]   head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] res,
  output logic                 ovf,
  output logic                 dz
);
  import ialu_pkg::*;

  localparam int NL  = (WORD_BITS + 31) / 32;
  localparam int LW  = $clog2(NL);
  localparam int PW  = 32 * NL + 32;
  localparam int CW  = $clog2(WORD_BITS);
  localparam logic [LW-1:0] LAST_LIMB = LW'(NL - 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(WORD_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t               state;
  state_t               state_next;

  cls_t                 h_cls;
  op_t                  h_op;
  logic [6:0]           h_s;
  logic [WORD_BITS-1:0] h_a;
  logic [WORD_BITS-1:0] h_b;

  logic [WORD_BITS-1:0] s_res;
  logic                 s_ovf;
  logic                 s_dz;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] diff;
  logic [7:0]           rs;

  logic                 out_free;
  logic                 load_simple;
  logic                 load_fin;

  // Multiplier state
  logic [32*NL-1:0]     ma;
  logic [32*NL-1:0]     mb;
  logic [LW-1:0]        mi;
  logic [LW-1:0]        mj;
  logic                 iss;
  logic [63:0]          prod;
  logic [LW-1:0]        prod_k;
  logic                 prod_v;
  logic [WORD_BITS-1:0] acc;
  logic [PW-1:0]        term;
  logic [31:0]          limb_a;
  logic [31:0]          limb_b;

  // Divider state
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] dvs;
  logic                 neg_q;
  logic [CW-1:0]        step;
  logic [WORD_BITS:0]   trial;
  logic                 fit;
  logic                 is_div;

  // Unpack the queue head
  assign h_cls = cls_t'(head[ENTRY_W-1 -: 2]);
  assign h_op  = op_t'(head[ENTRY_W-3 -: 5]);
  assign h_s   = head[2*WORD_BITS +: 7];
  assign h_a   = head[WORD_BITS +: WORD_BITS];
  assign h_b   = head[0 +: WORD_BITS];

  // Work out simple operations
  assign sum  = h_a + h_b;
  assign diff = h_a - h_b;
  assign rs   = 8'(WORD_BITS) - {1'b0, h_s};
  always_comb begin
    s_res = '0;
    s_ovf = 1'b0;
    s_dz  = 1'b0;
    case (h_op)
      OP_ADD: begin
        s_res = sum;
        s_ovf = (h_a[WORD_BITS-1] == h_b[WORD_BITS-1]) &&
                (sum[WORD_BITS-1] != h_a[WORD_BITS-1]);
      end
      OP_SUB: begin
        s_res = diff;
        s_ovf = (h_a[WORD_BITS-1] != h_b[WORD_BITS-1]) &&
                (diff[WORD_BITS-1] != h_a[WORD_BITS-1]);
      end
      OP_DIV: s_dz  = 1'b1;
      OP_AND: s_res = h_a & h_b;
      OP_OR:  s_res = h_a | h_b;
      OP_XOR: s_res = h_a ^ h_b;
      OP_NOT: s_res = ~h_a;
      OP_SHL: s_res = h_a << h_s;
      OP_SAR: s_res = WORD_BITS'($signed(h_a) >>> h_s);
      OP_ROL: s_res = (h_a << h_s) | (h_a >> rs);
      OP_ROR: s_res = (h_a >> h_s) | (h_a << rs);
      OP_EQ:  s_res = WORD_BITS'(h_a == h_b);
      OP_GT:  s_res = WORD_BITS'($signed(h_a) > $signed(h_b));
      OP_LT:  s_res = WORD_BITS'($signed(h_a) < $signed(h_b));
      OP_GE:  s_res = WORD_BITS'($signed(h_a) >= $signed(h_b));
      OP_LE:  s_res = WORD_BITS'($signed(h_a) <= $signed(h_b));
      default: s_res = '0;
    endcase
  end

  assign out_free    = !out_valid || out_ready;
  assign load_simple = (state == ST_IDLE) && !q_status.empty && (h_cls == CLS_SIMPLE) &&
                       out_free;
  assign load_fin    = (state == ST_FIN) && out_free;
  assign pop         = load_simple ||
                       ((state == ST_IDLE) && !q_status.empty && (h_cls != CLS_SIMPLE));

  // Sequence long operations
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty && h_cls == CLS_MUL) begin
          state_next = ST_MUL;
        end else if (!q_status.empty && h_cls == CLS_DIV) begin
          state_next = ST_DIV;
        end
      end
      ST_MUL: begin
        if (!iss && !prod_v) begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick one limb pair and place its product
  assign limb_a = ma[32*mi +: 32];
  assign limb_b = mb[32*mj +: 32];
  assign term   = {(PW-64)'(0), prod} << (32 * prod_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      if (state == ST_IDLE && pop && h_cls == CLS_MUL) begin
        iss <= 1'b1;
      end else if (state == ST_MUL && iss && mi == LAST_LIMB && mj == '0) begin
        iss <= 1'b0;
      end
      prod_v <= (state == ST_MUL) && iss;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop && h_cls == CLS_MUL) begin
      ma  <= (32*NL)'(h_a);
      mb  <= (32*NL)'(h_b);
      mi  <= '0;
      mj  <= '0;
      acc <= '0;
    end else if (state == ST_MUL) begin
      if (iss) begin
        prod   <= limb_a * limb_b;
        prod_k <= LW'(mi + mj);
        // Walk pairs whose weight stays within the word
        if (mj == LW'(LAST_LIMB - mi)) begin
          mi <= mi + 1'b1;
          mj <= '0;
        end else begin
          mj <= mj + 1'b1;
        end
      end
      if (prod_v) begin
        acc <= acc + term[WORD_BITS-1:0];
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit a cycle
  assign trial = {rem, quo[WORD_BITS-1]};
  assign fit   = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop && h_cls == CLS_DIV) begin
      quo   <= h_a[WORD_BITS-1] ? -h_a : h_a;
      dvs   <= h_b[WORD_BITS-1] ? -h_b : h_b;
      rem   <= '0;
      neg_q <= h_a[WORD_BITS-1] ^ h_b[WORD_BITS-1];
      step  <= LAST_STEP;
    end else if (state == ST_DIV) begin
      rem  <= fit ? WORD_BITS'(trial - {1'b0, dvs}) : trial[WORD_BITS-1:0];
      quo  <= {quo[WORD_BITS-2:0], fit};
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop) begin
      is_div <= (h_cls == CLS_DIV);
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_simple || load_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_simple) begin
      res <= s_res;
      ovf <= s_ovf;
      dz  <= s_dz;
    end else if (load_fin) begin
      res <= is_div ? (neg_q ? -quo : quo) : acc;
      ovf <= 1'b0;
      dz  <= 1'b0;
    end
  end

endmodule

// File: sv/int128_signed_alu.sv
// Top level of the signed integer ALU: front end, queue and back end.
//
// Signed two's complement ALU on WORD_BITS-bit words (64 to 128); operands use the low
// WORD_BITS bits of their halves and results come back sign-extended to 128 bits.
// Add, subtract, logic, shifts, rotates and comparisons go from the queue head straight
// into the output register, so while the output is taken a stream of them runs at one
// word per cycle. Multiply goes through one shared 32x32 multiplier, one limb pair a cycle,
// over NL = ceil(WORD_BITS/32) limbs. Divide produces one quotient bit a cycle. A zero
// divisor skips the divider and returns zero with divide_by_zero set. A four-word queue
// lets the front end keep accepting while the back end works on a long operation;
// results leave in order through a registered output.
module int128_signed_alu #(
  parameter int WORD_BITS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  operation,
  input  logic [63:0] a_high,
  input  logic [63:0] a_low,
  input  logic [63:0] b_high,
  input  logic [63:0] b_low,
  input  logic [6:0]  shift_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        overflow,
  output logic        divide_by_zero
);
  import ialu_pkg::*;

  localparam int ENTRY_W = 2 + 5 + 7 + 2 * WORD_BITS;

  q_status_t            q_status;
  logic                 push;
  logic                 pop;
  logic [ENTRY_W-1:0]   entry;
  logic [ENTRY_W-1:0]   head;
  logic [WORD_BITS-1:0] res;
  logic [127:0]         res_ext;

  ialu_front #(
    .WORD_BITS (WORD_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .a_high       (a_high),
    .a_low        (a_low),
    .b_high       (b_high),
    .b_low        (b_low),
    .shift_amount (shift_amount),
    .q_status     (q_status),
    .push         (push),
    .entry        (entry)
  );

  ialu_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ialu_back #(
    .WORD_BITS (WORD_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .ovf       (overflow),
    .dz        (divide_by_zero)
  );

  // Sign-extend the word to 128 bits
  assign res_ext     = 128'($signed(res));
  assign result_high = res_ext[127:64];
  assign result_low  = res_ext[63:0];

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    push |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("push into a full queue");

  // Back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // A zero divisor gives a zero result and no overflow
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (res == '0 && !overflow))
    else $error("divide by zero with nonzero result");

endmodule

// File: test/int128_signed_alu_tb.sv
// Self-checking testbench for the signed 128-bit integer ALU.
`timescale 1ns / 1ps

module int128_signed_alu_tb;
  import ialu_pkg::*;

  // Expected result of one word
  typedef struct {
    logic [127:0] value;
    logic         ovf;
    logic         dz;
  } alu_result_t;

  int unsigned mismatch_count = 0;

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // Compute the expected result of one operation
  function automatic alu_result_t compute_alu(input logic [4:0] opc, input logic [127:0] a,
                                              input logic [127:0] b, input logic [6:0] s);
    alu_result_t r;
    logic [127:0] na, nb, q;
    logic [255:0] rr;
    logic cmp;
    r.value = '0; r.ovf = 1'b0; r.dz = 1'b0; cmp = 1'b0;
    case (opc)
      OP_ADD: begin
        r.value = a + b;
        r.ovf = (a[127] == b[127]) && (r.value[127] != a[127]);
      end
      OP_SUB: begin
        r.value = a - b;
        r.ovf = (a[127] != b[127]) && (r.value[127] != a[127]);
      end
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          na = a[127] ? -a : a;
          nb = b[127] ? -b : b;
          q = na / nb;
          r.value = (a[127] ^ b[127]) ? -q : q;
        end
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_NOT: r.value = ~a;
      OP_SHL: r.value = a << s;
      OP_SAR: r.value = $signed(a) >>> s;
      OP_ROL: begin
        rr = {a, a} << s;
        r.value = rr[255:128];
      end
      OP_ROR: begin
        rr = {a, a} >> s;
        r.value = rr[127:0];
      end
      OP_EQ: cmp = (a == b);
      OP_GT: cmp = $signed(a) > $signed(b);
      OP_LT: cmp = $signed(a) < $signed(b);
      OP_GE: cmp = $signed(a) >= $signed(b);
      OP_LE: cmp = $signed(a) <= $signed(b);
      default: ;
    endcase
    if (opc >= OP_EQ && opc <= OP_LE) r.value = {127'd0, cmp};
    return r;
  endfunction

  // Ordered store of results still owed by the block
  class alu_scoreboard;
    alu_result_t pending[$];

    function void note_word(input logic [4:0] opc, input logic [127:0] a,
                            input logic [127:0] b, input logic [6:0] s);
      pending.push_back(compute_alu(opc, a, b, s));
    endfunction

    task check_word(input logic [127:0] v, input logic ovf, input logic dz);
      alu_result_t e;
      if (pending.size() == 0) begin
        report("unexpected word", v, '0);
      end else begin
        e = pending.pop_front();
        if (v[127:64] !== e.value[127:64])
          report("result_high", 128'(v[127:64]), 128'(e.value[127:64]));
        if (v[63:0] !== e.value[63:0])
          report("result_low", 128'(v[63:0]), 128'(e.value[63:0]));
        if (ovf !== e.ovf) report("overflow", 128'(ovf), 128'(e.ovf));
        if (dz !== e.dz) report("divide_by_zero", 128'(dz), 128'(e.dz));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  operation = '0;
  logic [63:0] a_high = '0, a_low = '0, b_high = '0, b_low = '0;
  logic [6:0]  shift_amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_high, result_low;
  logic        overflow, divide_by_zero;

  alu_scoreboard board = new();
  bit stimulus_done = 1'b0;
  bit hold_output = 1'b0;

  localparam logic [127:0] MIN_VAL = {1'b1, 127'd0};
  localparam logic [127:0] MAX_VAL = {1'b0, {127{1'b1}}};
  localparam logic [127:0] NEG_ONE = {128{1'b1}};

  always #6 clk = ~clk;

  int128_signed_alu DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .a_high(a_high), .a_low(a_low),
    .b_high(b_high), .b_low(b_low), .shift_amount(shift_amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low),
    .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

  // Offer one word and wait until it is taken
  task automatic send_word(input logic [4:0] opc, input logic [127:0] a,
                           input logic [127:0] b, input logic [6:0] s);
    in_valid <= 1'b1;
    operation <= opc;
    {a_high, a_low} <= a;
    {b_high, b_low} <= b;
    shift_amount <= s;
    do @(posedge clk); while (!in_ready);
    board.note_word(opc, a, b, s);
  endtask

  task automatic go_idle(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pick an operand biased towards edge values
  function automatic logic [127:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return NEG_ONE;
      3: return 128'd0;
      4: return 128'($urandom_range(0, 5));
      5: return {{96{1'b1}}, 32'($urandom)};
      6: return {64'd0, 32'($urandom), 32'($urandom)};
      default: return {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Stimulus: directed words, then random bursts
  initial begin
    logic [127:0] a, b;
    logic [4:0] opc;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_ADD, MAX_VAL, 128'd1, 7'd0);
    send_word(OP_ADD, MIN_VAL, NEG_ONE, 7'd0);
    send_word(OP_SUB, MIN_VAL, 128'd1, 7'd0);
    send_word(OP_SUB, MAX_VAL, NEG_ONE, 7'd0);
    send_word(OP_MUL, MAX_VAL, MAX_VAL, 7'd0);
    send_word(OP_MUL, NEG_ONE, MIN_VAL, 7'd0);
    send_word(OP_DIV, MIN_VAL, NEG_ONE, 7'd0);
    send_word(OP_DIV, 128'd0, 128'd0, 7'd0);
    send_word(OP_DIV, MAX_VAL, 128'd0, 7'd0);
    send_word(OP_DIV, -128'sd7, 128'd2, 7'd0);
    send_word(OP_AND, NEG_ONE, MAX_VAL, 7'd0);
    send_word(OP_OR, MIN_VAL, 128'd1, 7'd0);
    send_word(OP_XOR, NEG_ONE, MAX_VAL, 7'd0);
    send_word(OP_NOT, 128'd0, NEG_ONE, 7'd127);
    send_word(OP_SHL, NEG_ONE, 128'd5, 7'd0);
    send_word(OP_SHL, 128'd1, 128'd0, 7'd127);
    send_word(OP_SAR, MIN_VAL, 128'd0, 7'd127);
    send_word(OP_SAR, MIN_VAL, 128'd0, 7'd0);
    send_word(OP_ROL, MIN_VAL | 128'd1, 128'd0, 7'd1);
    send_word(OP_ROR, 128'd1, 128'd0, 7'd127);
    send_word(OP_EQ, MIN_VAL, MIN_VAL, 7'd0);
    send_word(OP_GT, MAX_VAL, MIN_VAL, 7'd0);
    send_word(OP_LT, MIN_VAL, MAX_VAL, 7'd0);
    send_word(OP_GE, NEG_ONE, NEG_ONE, 7'd0);
    send_word(OP_LE, 128'd0, NEG_ONE, 7'd0);
    send_word(5'd31, NEG_ONE, NEG_ONE, 7'd127);

    // Pause until everything owed has come back
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 1450; n++) begin
      if (n == 400) hold_output = 1'b1;
      if (n == 800) begin
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      opc = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31)) :
            5'($urandom_range(0, 16));
      a = pick_operand();
      b = pick_operand();
      if (opc == OP_DIV && $urandom_range(0, 1)) b = 128'($urandom_range(1, 1000));
      send_word(opc, a, b, 7'($urandom));
      // Bursts with random gaps between them
      if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        go_idle(burst);
      end
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: own stall pattern plus one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_word({result_high, result_low}, overflow, divide_by_zero);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        phase++;
        if ((phase / 64) % 3 == 2) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Finish once all words are back
  initial begin
    wait (stimulus_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("int128_signed_alu test passed");
    end else begin
      $display("int128_signed_alu test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 2000000);
    $display("int128_signed_alu test failed");
    $finish;
  end

endmodule
